// ===== hw/rtl/height_to_rainbow_color_core_assert.svh =====
// Assertion macros shared by the colour map RTL.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef HEIGHT_TO_RAINBOW_COLOR_CORE_ASSERT_SVH
`define HEIGHT_TO_RAINBOW_COLOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HRC_ASSERT_NEVER(lbl, cond, msg) \
  `HRC_ASSERT(lbl, !(cond), msg)
`else
`define HRC_ASSERT(lbl, prop, msg)
`define HRC_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/hrc_pkg.sv =====
`default_nettype none
package hrc_pkg;

  // Colour depth; all ones means full intensity
  localparam int unsigned COLOR_BITS = 8;
  localparam logic [COLOR_BITS-1:0] CMAX = {COLOR_BITS{1'b1}};
  localparam logic [COLOR_BITS-1:0] HALF_COLOR = {1'b1, {(COLOR_BITS-1){1'b0}}};

  // One quotient bit per divider stage
  localparam int unsigned DIV_STEPS = 16;
  // Register stages from accepted beat to result strobe
  localparam int unsigned PIPE_DEPTH = DIV_STEPS + 6;

  // Register reset values
  localparam logic [31:0] HEIGHT_LOW_RST  = 32'h0000_0000;
  localparam logic [31:0] HEIGHT_HIGH_RST = 32'h0001_0000;
  localparam logic [15:0] HUE_FACTOR_RST  = 16'd26214;

  // Register index on the configuration port
  typedef enum logic [1:0] {
    REG_HEIGHT_LOW  = 2'd0,
    REG_HEIGHT_HIGH = 2'd1,
    REG_HUE_FACTOR  = 2'd2
  } hrc_reg_e;

  // Hue sectors of the rainbow
  typedef enum logic [2:0] {
    SECTOR_RED_YELLOW    = 3'd0,
    SECTOR_YELLOW_GREEN  = 3'd1,
    SECTOR_GREEN_CYAN    = 3'd2,
    SECTOR_CYAN_BLUE     = 3'd3,
    SECTOR_BLUE_MAGENTA  = 3'd4,
    SECTOR_MAGENTA_RED   = 3'd5
  } hrc_sector_e;

  // Flags that travel with a beat through the divider
  typedef struct packed {
    logic invalid;   // empty height range
    logic clamp_lo;  // height at or below the lower bound
    logic clamp_hi;  // height at or above the upper bound
  } hrc_tag_t;

endpackage
`default_nettype wire

// ===== hw/rtl/hrc_div.sv =====
`default_nettype none
`include "height_to_rainbow_color_core_assert.svh"
// Pipelined restoring divider: quot = floor(rem * 2^16 / span) for rem < span,
// one quotient bit per stage.
module hrc_div import hrc_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire hrc_tag_t       in_tag_i,
  input  wire logic [31:0]    rem_i,
  input  wire logic [31:0]    span_i,
  output logic                out_valid_o,
  output hrc_tag_t            out_tag_o,
  output logic [DIV_STEPS-1:0] quot_o
);

  logic                 valid_q [DIV_STEPS];
  hrc_tag_t             tag_q   [DIV_STEPS];
  logic [31:0]          rem_q   [DIV_STEPS];
  logic [31:0]          span_q  [DIV_STEPS];
  logic [DIV_STEPS-1:0] quot_q  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic                 prev_valid;
    hrc_tag_t             prev_tag;
    logic [31:0]          prev_rem;
    logic [31:0]          prev_span;
    logic [DIV_STEPS-1:0] prev_quot;
    logic [32:0]          shl;
    logic                 take;
    logic [32:0]          diff;
    logic [31:0]          rem_d;
    logic [DIV_STEPS-1:0] quot_d;

    // Pick up the previous stage, or the input beat for the first one
    if (k == 0) begin : g_first
      assign prev_valid = in_valid_i;
      assign prev_tag   = in_tag_i;
      assign prev_rem   = rem_i;
      assign prev_span  = span_i;
      assign prev_quot  = '0;
    end else begin : g_next
      assign prev_valid = valid_q[k-1];
      assign prev_tag   = tag_q[k-1];
      assign prev_rem   = rem_q[k-1];
      assign prev_span  = span_q[k-1];
      assign prev_quot  = quot_q[k-1];
    end

    // Shift in one numerator zero, subtract the divisor where it fits
    assign shl    = {prev_rem, 1'b0};
    assign take   = (shl >= {1'b0, prev_span});
    assign diff   = shl - {1'b0, prev_span};
    assign rem_d  = take ? diff[31:0] : shl[31:0];
    assign quot_d = {prev_quot[DIV_STEPS-2:0], take};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      tag_q[k]  <= prev_tag;
      rem_q[k]  <= rem_d;
      span_q[k] <= prev_span;
      quot_q[k] <= quot_d;
    end
  end

  assign out_valid_o = valid_q[DIV_STEPS-1];
  assign out_tag_o   = tag_q[DIV_STEPS-1];
  assign quot_o      = quot_q[DIV_STEPS-1];

  `HRC_ASSERT(a_div_latency, in_valid_i |-> ##DIV_STEPS out_valid_o, "divider lost a beat")
  `HRC_ASSERT_NEVER(a_div_clamp_both, out_valid_o && out_tag_o.clamp_lo && out_tag_o.clamp_hi, "both clamps set")
  `HRC_ASSERT(a_div_rem_below, (out_valid_o && !out_tag_o.invalid && !out_tag_o.clamp_lo && !out_tag_o.clamp_hi) |-> (rem_q[DIV_STEPS-1] < span_q[DIV_STEPS-1]), "remainder not below divisor")

endmodule
`default_nettype wire

// ===== hw/rtl/height_to_rainbow_color_core.sv =====
`default_nettype none
`include "height_to_rainbow_color_core_assert.svh"
// Channel   Ports                                   Beat taken when
// -------   -------------------------------------   ------------------------------
// input     start, busy, height_i                   start high, busy low
// result    done_o, red_o, green_o, blue_o,         done_o high (one cycle)
//           range_invalid_o
// config    psel, penable, pwrite, paddr, pwdata,   psel, penable, pwrite, pready
//           prdata, pready
//
// One beat enters every cycle; each passes the range and clamp stages, the 16-stage
// divider, then the hue, sector, colour and output stages to its result.
// busy stays low: the pipeline always advances and the receiver cannot stall.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
module height_to_rainbow_color_core import hrc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [31:0]           height_i,
  output logic                       done_o,
  output logic [COLOR_BITS-1:0]      red_o,
  output logic [COLOR_BITS-1:0]      green_o,
  output logic [COLOR_BITS-1:0]      blue_o,
  output logic                       range_invalid_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam logic [COLOR_BITS+31:0] ROUND_HALF = {{(COLOR_BITS+1){1'b0}}, 1'b1, 30'b0};
  localparam logic [16:0] U_ONE = 17'h1_0000;
  localparam logic [31:0] Q31_ONE = 32'h8000_0000;

  // ---------------- configuration registers ----------------
  logic [31:0] low_q, high_q;
  logic [15:0] hue_q;
  logic        cfg_wr;
  hrc_reg_e    cfg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = hrc_reg_e'(paddr[3:2]);

  // Write a register at the access beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= HEIGHT_LOW_RST;
      high_q <= HEIGHT_HIGH_RST;
      hue_q  <= HUE_FACTOR_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HEIGHT_LOW:  low_q  <= pwdata;
        REG_HEIGHT_HIGH: high_q <= pwdata;
        REG_HUE_FACTOR:  hue_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (cfg_idx)
      REG_HEIGHT_LOW:  prdata = low_q;
      REG_HEIGHT_HIGH: prdata = high_q;
      REG_HUE_FACTOR:  prdata = {16'b0, hue_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------- stage A: offset and span ----------------
  logic        a_valid_q, a_inv_q;
  logic [32:0] a_d_q;
  logic [31:0] a_span_q;
  logic [32:0] a_d_d;
  logic [31:0] a_span_d;
  logic        a_inv_d;

  assign a_d_d    = {height_i[31], height_i} - {low_q[31], low_q};
  assign a_span_d = high_q - low_q;
  assign a_inv_d  = ($signed(high_q) <= $signed(low_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a_d_q    <= a_d_d;
    a_span_q <= a_span_d;
    a_inv_q  <= a_inv_d;
  end

  // ---------------- stage B: clamp ----------------
  logic        b_valid_q;
  hrc_tag_t    b_tag_q, b_tag_d;
  logic [31:0] b_rem_q, b_span_q;

  always_comb begin
    b_tag_d.invalid  = a_inv_q;
    b_tag_d.clamp_lo = a_d_q[32] || (a_d_q == '0);
    b_tag_d.clamp_hi = !b_tag_d.clamp_lo && (a_d_q[31:0] >= a_span_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_tag_q  <= b_tag_d;
    b_rem_q  <= a_d_q[31:0];
    b_span_q <= a_span_q;
  end

  // ---------------- divider ----------------
  logic                 dv_valid;
  hrc_tag_t             dv_tag;
  logic [DIV_STEPS-1:0] dv_quot;

  hrc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_valid_q),
    .in_tag_i    (b_tag_q),
    .rem_i       (b_rem_q),
    .span_i      (b_span_q),
    .out_valid_o (dv_valid),
    .out_tag_o   (dv_tag),
    .quot_o      (dv_quot)
  );

  // ---------------- stage M: invert and scale hue ----------------
  logic        m_valid_q, m_inv_q;
  logic [30:0] m_frac_q;
  logic [16:0] m_u_d;
  logic [32:0] m_h_d;

  always_comb begin
    if (dv_tag.clamp_lo) begin
      m_u_d = U_ONE;
    end else if (dv_tag.clamp_hi) begin
      m_u_d = '0;
    end else begin
      m_u_d = U_ONE - {1'b0, dv_quot};
    end
    m_h_d = {16'b0, m_u_d} * {17'b0, hue_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    m_inv_q  <= dv_tag.invalid;
    m_frac_q <= m_h_d[30:0];
  end

  // ---------------- stage S: sector split ----------------
  logic        s_valid_q, s_inv_q;
  hrc_sector_e s_sector_q;
  logic [30:0] s_part_q;
  logic [33:0] s_s6_d;

  assign s_s6_d = {3'b0, m_frac_q} * 34'd6;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s_inv_q    <= m_inv_q;
    s_sector_q <= hrc_sector_e'(s_s6_d[33:31]);
    s_part_q   <= s_s6_d[30:0];
  end

  // ---------------- stage N: mirror and convert to colour ----------------
  logic                  n_valid_q, n_inv_q;
  hrc_sector_e           n_sector_q;
  logic [COLOR_BITS-1:0] n_color_q;
  logic [31:0]           n_n_d;
  logic [COLOR_BITS+31:0] n_sum_d;

  assign n_n_d   = s_sector_q[0] ? (Q31_ONE - {1'b0, s_part_q}) : {1'b0, s_part_q};
  assign n_sum_d = ({{COLOR_BITS{1'b0}}, n_n_d} * {32'b0, CMAX}) + ROUND_HALF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_valid_q <= 1'b0;
    end else begin
      n_valid_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    n_inv_q    <= s_inv_q;
    n_sector_q <= s_sector_q;
    n_color_q  <= n_sum_d[31 +: COLOR_BITS];
  end

  // ---------------- stage O: assemble the colour ----------------
  logic                  done_q, inv_q;
  logic [COLOR_BITS-1:0] red_q, green_q, blue_q;
  logic [COLOR_BITS-1:0] red_d, green_d, blue_d;

  always_comb begin
    if (n_inv_q) begin
      red_d   = CMAX;
      green_d = HALF_COLOR;
      blue_d  = HALF_COLOR;
    end else begin
      case (n_sector_q)
        SECTOR_RED_YELLOW: begin
          red_d = CMAX;      green_d = n_color_q; blue_d = '0;
        end
        SECTOR_YELLOW_GREEN: begin
          red_d = n_color_q; green_d = CMAX;      blue_d = '0;
        end
        SECTOR_GREEN_CYAN: begin
          red_d = '0;        green_d = CMAX;      blue_d = n_color_q;
        end
        SECTOR_CYAN_BLUE: begin
          red_d = '0;        green_d = n_color_q; blue_d = CMAX;
        end
        SECTOR_BLUE_MAGENTA: begin
          red_d = n_color_q; green_d = '0;        blue_d = CMAX;
        end
        default: begin
          red_d = CMAX;      green_d = '0;        blue_d = n_color_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= n_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    inv_q   <= n_inv_q;
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign done_o          = done_q;
  assign range_invalid_o = inv_q;
  assign red_o           = red_q;
  assign green_o         = green_q;
  assign blue_o          = blue_q;

  `HRC_ASSERT(a_result_follows, (start && !busy) |-> ##PIPE_DEPTH done_o, "accepted beat gave no result")
  `HRC_ASSERT(a_no_phantom, !start |-> ##PIPE_DEPTH !done_o, "result without accepted beat")
  `HRC_ASSERT(a_fallback_colour, (done_o && range_invalid_o) |-> (red_o == CMAX && green_o == HALF_COLOR && blue_o == HALF_COLOR), "wrong fallback colour")
  `HRC_ASSERT(a_full_and_zero, (done_o && !range_invalid_o) |-> ((red_o == CMAX || green_o == CMAX || blue_o == CMAX) && (red_o == '0 || green_o == '0 || blue_o == '0)), "colour not fully saturated")

endmodule
`default_nettype wire
